// ----- rtl/core/alp_pkg.sv -----
// alp_pkg: shared types, sizes and codes for the array list engine.
// Used by alp_ctrl, alp_datapath, array_list_engine and the testbench; depends on nothing.
package alp_pkg;

  // List capacity and derived widths
  localparam int CAPACITY = 64;
  localparam int DATA_W   = 32;
  localparam int OP_W     = 3;
  localparam int POS_W    = 7;
  localparam int STAT_W   = 2;
  localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  typedef logic [OP_W-1:0]          op_t;
  typedef logic [POS_W-1:0]         pos_t;
  typedef logic [STAT_W-1:0]        stat_code_t;
  typedef logic [ADDR_W-1:0]        addr_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic [CMP_W-1:0]         cmp_t;
  typedef logic signed [DATA_W-1:0] data_t;

  // Operation codes
  localparam op_t OP_INSERT   = 3'd0;
  localparam op_t OP_DELETE   = 3'd1;
  localparam op_t OP_LOCATE   = 3'd2;
  localparam op_t OP_RETRIEVE = 3'd3;
  localparam op_t OP_MINIMUM  = 3'd4;

  // Status codes
  localparam stat_code_t ST_OK     = 2'd0;
  localparam stat_code_t ST_FULL   = 2'd1;
  localparam stat_code_t ST_BADPOS = 2'd2;
  localparam stat_code_t ST_EMPTY  = 2'd3;

  // Controller to datapath commands
  typedef struct packed {
    logic       load_req;   // capture the accepted transaction
    logic       check;      // init walk pointer and result accumulators
    logic       rd_en;      // read entry at pointer, step pointer
    logic       consume;    // use read data from previous cycle
    logic       put;        // write inserted value at its position
    logic       cnt_inc;
    logic       cnt_dec;
    logic       out_load;   // fill output register
    stat_code_t out_status;
  } alp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    op_t  op;
    logic full;
    logic empty;
    logic ins_ok;       // 1 <= pos <= count+1
    logic del_ok;       // 1 <= pos <= count
    logic ins_noshift;  // pos == count+1
    logic del_noshift;  // pos == count
    logic ptr_last;     // pointer sits on the final entry of the walk
  } alp_stat_t;

endpackage

// ----- rtl/core/alp_ram.sv -----
// alp_ram: generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
module alp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                      wr_data,
  input  logic                                  rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/core/alp_datapath.sv -----
// alp_datapath: request registers, entry count, walk pointer, entry memory,
// scan accumulators and output register. Depends on alp_pkg and alp_ram.
module alp_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  alp_pkg::alp_cmd_t    cmd,
  output alp_pkg::alp_stat_t   stat,
  input  alp_pkg::op_t         in_operation,
  input  alp_pkg::pos_t        in_position,
  input  alp_pkg::data_t       in_value,
  output alp_pkg::stat_code_t  out_status,
  output logic                 out_found,
  output alp_pkg::pos_t        out_result_position,
  output alp_pkg::data_t       out_result_value,
  output alp_pkg::pos_t        out_entry_count
);

  alp_pkg::op_t   op_r;
  alp_pkg::pos_t  pos_r;
  alp_pkg::data_t val_r;
  alp_pkg::cnt_t  count_r;
  alp_pkg::addr_t ptr_r;
  alp_pkg::addr_t prev_r;
  logic           found_r;
  logic           acc_vld_r;
  alp_pkg::pos_t  res_pos_r;
  alp_pkg::data_t res_val_r;

  alp_pkg::stat_code_t out_status_r;
  logic                out_found_r;
  alp_pkg::pos_t       out_pos_r;
  alp_pkg::data_t      out_val_r;
  alp_pkg::pos_t       out_cnt_r;

  alp_pkg::cmp_t  pos_x;
  alp_pkg::cmp_t  cnt_x;
  alp_pkg::addr_t ptr_init;
  alp_pkg::addr_t wr_addr;
  alp_pkg::data_t wr_data;
  logic           wr_en;
  logic [alp_pkg::DATA_W-1:0] ram_rdata;
  alp_pkg::data_t rdata;

  assign pos_x = alp_pkg::cmp_t'(pos_r);
  assign cnt_x = alp_pkg::cmp_t'(count_r);
  assign rdata = alp_pkg::data_t'(ram_rdata);

  // Range checks on the held request
  always_comb begin
    stat.op          = op_r;
    stat.full        = (cnt_x >= alp_pkg::cmp_t'(alp_pkg::CAPACITY));
    stat.empty       = (count_r == '0);
    stat.ins_ok      = (pos_x != '0) && (pos_x <= cnt_x + alp_pkg::cmp_t'(1));
    stat.del_ok      = (pos_x != '0) && (pos_x <= cnt_x);
    stat.ins_noshift = (pos_x == cnt_x + alp_pkg::cmp_t'(1));
    stat.del_noshift = (pos_x == cnt_x);
    case (op_r)
      alp_pkg::OP_INSERT:   stat.ptr_last = (ptr_r == alp_pkg::addr_t'(pos_x - 1'b1));
      alp_pkg::OP_RETRIEVE: stat.ptr_last = 1'b1;
      default:              stat.ptr_last = (ptr_r == alp_pkg::addr_t'(cnt_x - 1'b1));
    endcase
  end

  // Start address of the walk
  always_comb begin
    case (op_r)
      alp_pkg::OP_INSERT:   ptr_init = alp_pkg::addr_t'(cnt_x - 1'b1);
      alp_pkg::OP_DELETE:   ptr_init = alp_pkg::addr_t'(pos_x);
      alp_pkg::OP_RETRIEVE: ptr_init = alp_pkg::addr_t'(pos_x - 1'b1);
      default:              ptr_init = '0;
    endcase
  end

  // Write port: inserted value, or shifted entry one place up or down
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = alp_pkg::addr_t'(pos_x - 1'b1);
    wr_data = val_r;
    if (cmd.put) begin
      wr_en = 1'b1;
    end else if (cmd.consume) begin
      wr_data = rdata;
      if (op_r == alp_pkg::OP_INSERT) begin
        wr_en   = 1'b1;
        wr_addr = prev_r + alp_pkg::addr_t'(1);
      end else if (op_r == alp_pkg::OP_DELETE) begin
        wr_en   = 1'b1;
        wr_addr = prev_r - alp_pkg::addr_t'(1);
      end
    end
  end

  alp_ram #(
    .WIDTH (alp_pkg::DATA_W),
    .DEPTH (alp_pkg::CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (cmd.rd_en),
    .rd_addr (ptr_r),
    .rd_data (ram_rdata)
  );

  // Entry count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.cnt_inc) begin
      count_r <= count_r + alp_pkg::cnt_t'(1);
    end else if (cmd.cnt_dec) begin
      count_r <= count_r - alp_pkg::cnt_t'(1);
    end
  end

  // Request capture, walk pointer and scan accumulators
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      op_r  <= in_operation;
      pos_r <= in_position;
      val_r <= in_value;
    end
    if (cmd.check) begin
      ptr_r     <= ptr_init;
      found_r   <= 1'b0;
      acc_vld_r <= 1'b0;
      res_val_r <= '0;
      res_pos_r <= (op_r == alp_pkg::OP_LOCATE) ?
                   alp_pkg::pos_t'(cnt_x + alp_pkg::cmp_t'(1)) : '0;
    end else if (cmd.rd_en) begin
      prev_r <= ptr_r;
      ptr_r  <= (op_r == alp_pkg::OP_INSERT) ? ptr_r - alp_pkg::addr_t'(1)
                                             : ptr_r + alp_pkg::addr_t'(1);
    end
    if (cmd.consume) begin
      case (op_r)
        alp_pkg::OP_LOCATE: begin
          if (!found_r && (rdata == val_r)) begin
            found_r   <= 1'b1;
            res_pos_r <= alp_pkg::pos_t'(alp_pkg::cmp_t'(prev_r) + alp_pkg::cmp_t'(1));
          end
        end
        alp_pkg::OP_RETRIEVE: begin
          res_val_r <= rdata;
        end
        alp_pkg::OP_MINIMUM: begin
          if (!acc_vld_r || (rdata < res_val_r)) begin
            res_val_r <= rdata;
          end
          acc_vld_r <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= cmd.out_status;
      out_found_r  <= found_r;
      out_pos_r    <= res_pos_r;
      out_val_r    <= res_val_r;
      out_cnt_r    <= alp_pkg::pos_t'(count_r);
    end
  end

  assign out_status          = out_status_r;
  assign out_found           = out_found_r;
  assign out_result_position = out_pos_r;
  assign out_result_value    = out_val_r;
  assign out_entry_count     = out_cnt_r;

endmodule

// ----- rtl/core/alp_ctrl.sv -----
// alp_ctrl: sequencer for list operations and the output handshake.
// Depends on alp_pkg; drives alp_datapath through command/status structs.
module alp_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  alp_pkg::alp_stat_t stat,
  output alp_pkg::alp_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_WALK,
    S_DRAIN,
    S_PUT,
    S_FIN
  } state_t;

  state_t              state_r, state_nxt;
  alp_pkg::stat_code_t status_r, status_nxt;
  logic                pend_r, pend_nxt;
  logic                out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // Next state and commands
  always_comb begin
    state_nxt      = state_r;
    status_nxt     = status_r;
    pend_nxt       = 1'b0;
    out_valid_nxt  = out_valid_r && !out_ready;
    cmd            = '0;
    cmd.out_status = status_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_nxt    = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.check  = 1'b1;
        status_nxt = alp_pkg::ST_OK;
        state_nxt  = S_FIN;
        case (stat.op)
          alp_pkg::OP_INSERT: begin
            if (stat.full) begin
              status_nxt = alp_pkg::ST_FULL;
            end else if (!stat.ins_ok) begin
              status_nxt = alp_pkg::ST_BADPOS;
            end else if (stat.ins_noshift) begin
              state_nxt = S_PUT;
            end else begin
              state_nxt = S_WALK;
            end
          end
          alp_pkg::OP_DELETE: begin
            if (!stat.del_ok) begin
              status_nxt = alp_pkg::ST_BADPOS;
            end else if (stat.del_noshift) begin
              cmd.cnt_dec = 1'b1;
            end else begin
              state_nxt = S_WALK;
            end
          end
          alp_pkg::OP_LOCATE: begin
            if (!stat.empty) begin
              state_nxt = S_WALK;
            end
          end
          alp_pkg::OP_RETRIEVE: begin
            if (!stat.del_ok) begin
              status_nxt = alp_pkg::ST_BADPOS;
            end else begin
              state_nxt = S_WALK;
            end
          end
          alp_pkg::OP_MINIMUM: begin
            if (stat.empty) begin
              status_nxt = alp_pkg::ST_EMPTY;
            end else begin
              state_nxt = S_WALK;
            end
          end
          default: begin
          end
        endcase
      end
      S_WALK: begin
        // one read per cycle, previous read data consumed alongside
        cmd.rd_en   = 1'b1;
        cmd.consume = pend_r;
        pend_nxt    = 1'b1;
        if (stat.ptr_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        cmd.consume = 1'b1;
        if (stat.op == alp_pkg::OP_INSERT) begin
          state_nxt = S_PUT;
        end else begin
          cmd.cnt_dec = (stat.op == alp_pkg::OP_DELETE);
          state_nxt   = S_FIN;
        end
      end
      S_PUT: begin
        cmd.put     = 1'b1;
        cmd.cnt_inc = 1'b1;
        state_nxt   = S_FIN;
      end
      S_FIN: begin
        // wait for a free output register
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      status_r    <= alp_pkg::ST_OK;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      status_r    <= status_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- rtl/core/array_list_engine.sv -----
// array_list_engine: ordered list of signed 32-bit values in one RAM.
// Rejects, ignored ops, a locate on an empty list and a last-entry delete go straight to the result;
// an append insert writes the value first; other ops walk the list, a shifting insert then writes.
// Throughput: one transaction at a time; in_ready rises in the same cycle as out_valid,
// later while an unaccepted result holds the output register.
// Reset: synchronous active-low rst_n clears count and control; entries stay unwritten.
module array_list_engine (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  alp_pkg::op_t        in_operation,
  input  alp_pkg::pos_t       in_position,
  input  alp_pkg::data_t      in_value,
  output logic                out_valid,
  input  logic                out_ready,
  output alp_pkg::stat_code_t out_status,
  output logic                out_found,
  output alp_pkg::pos_t       out_result_position,
  output alp_pkg::data_t      out_result_value,
  output alp_pkg::pos_t       out_entry_count
);

  alp_pkg::alp_cmd_t  cmd;
  alp_pkg::alp_stat_t stat;

  alp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  alp_datapath u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .stat                (stat),
    .in_operation        (in_operation),
    .in_position         (in_position),
    .in_value            (in_value),
    .out_status          (out_status),
    .out_found           (out_found),
    .out_result_position (out_result_position),
    .out_result_value    (out_result_value),
    .out_entry_count     (out_entry_count)
  );

endmodule

// ----- bench/array_list_engine_test.sv -----
// array_list_engine_test: self-checking testbench for the array list engine.
// Drives list requests with random idling on both channels and checks each reply
// against a list model kept here. Depends on alp_pkg and array_list_engine.
`timescale 1ns / 100ps

module array_list_engine_test;
  import alp_pkg::*;

  // Codes the package leaves unnamed: the block ignores these
  localparam op_t OP_RSVD_LO = 3'd5;
  localparam op_t OP_RSVD_HI = 3'd7;
  localparam pos_t POS_TOP = 7'h7F;
  localparam data_t VAL_MAX = 32'sh7FFF_FFFF;
  localparam data_t VAL_MIN = 32'sh8000_0000;

  // Idling modes
  localparam int IDLE_NONE = 0;
  localparam int IDLE_SEND = 1;
  localparam int IDLE_RECV = 2;
  localparam int IDLE_BOTH = 3;

  typedef struct {
    stat_code_t status;
    logic       found;
    pos_t       rpos;
    data_t      rval;
    pos_t       entry_count;
  } list_reply_t;

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  in_valid = 1'b0;
  logic  in_ready;
  op_t   in_operation = OP_INSERT;
  pos_t  in_position = '0;
  data_t in_value = '0;
  logic  out_valid;
  logic  out_ready = 1'b0;
  stat_code_t out_status;
  logic  out_found;
  pos_t  out_result_position;
  data_t out_result_value;
  pos_t  out_entry_count;

  // List model and the replies still owed by the block
  data_t       list_mem [CAPACITY];
  int          list_len = 0;
  list_reply_t owed_replies [$];
  int          err_cnt = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;

  array_list_engine dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_operation        (in_operation),
    .in_position         (in_position),
    .in_value            (in_value),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_status          (out_status),
    .out_found           (out_found),
    .out_result_position (out_result_position),
    .out_result_value    (out_result_value),
    .out_entry_count     (out_entry_count)
  );

  always #5 clk = ~clk;

  // Receiver back-pressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Apply one request to the list model and return the reply it should give
  function automatic list_reply_t apply_list_op(op_t op, pos_t pos, data_t val);
    list_reply_t r;
    int p;
    r.status = ST_OK;
    r.found = 1'b0;
    r.rpos = '0;
    r.rval = '0;
    p = pos;
    case (op)
      OP_INSERT: begin
        if (list_len >= CAPACITY) r.status = ST_FULL;
        else if (p < 1 || p > list_len + 1) r.status = ST_BADPOS;
        else begin
          for (int i = list_len; i >= p; i--) list_mem[i] = list_mem[i-1];
          list_mem[p-1] = val;
          list_len++;
        end
      end
      OP_DELETE: begin
        if (p < 1 || p > list_len) r.status = ST_BADPOS;
        else begin
          for (int i = p; i < list_len; i++) list_mem[i-1] = list_mem[i];
          list_len--;
        end
      end
      OP_LOCATE: begin
        r.rpos = pos_t'(list_len + 1);
        for (int i = 0; i < list_len; i++) begin
          if (list_mem[i] == val) begin
            r.found = 1'b1;
            r.rpos = pos_t'(i + 1);
            break;
          end
        end
      end
      OP_RETRIEVE: begin
        if (p < 1 || p > list_len) r.status = ST_BADPOS;
        else r.rval = list_mem[p-1];
      end
      OP_MINIMUM: begin
        if (list_len == 0) r.status = ST_EMPTY;
        else begin
          r.rval = list_mem[0];
          for (int i = 1; i < list_len; i++)
            if (list_mem[i] < r.rval) r.rval = list_mem[i];
        end
      end
      default: ;
    endcase
    r.entry_count = pos_t'(list_len);
    return r;
  endfunction

  // Reply checker: compare each accepted reply with the oldest one owed
  always @(posedge clk) begin
    list_reply_t want;
    if (rst_n && out_valid && out_ready) begin
      if (owed_replies.size() == 0) begin
        $error("unexpected reply: status %0d count %0d", out_status, out_entry_count);
        err_cnt++;
      end else begin
        want = owed_replies.pop_front();
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          err_cnt++;
        end
        if (out_found !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, out_found);
          err_cnt++;
        end
        if (out_result_position !== want.rpos) begin
          $error("result_position: expected %0d, got %0d", want.rpos, out_result_position);
          err_cnt++;
        end
        if (out_result_value !== want.rval) begin
          $error("result_value: expected %0d, got %0d", want.rval, out_result_value);
          err_cnt++;
        end
        if (out_entry_count !== want.entry_count) begin
          $error("entry_count: expected %0d, got %0d", want.entry_count, out_entry_count);
          err_cnt++;
        end
      end
    end
  end

  // Send one request; valid stays up for a back-to-back follower
  task automatic send_req(op_t op, pos_t pos, data_t val);
    int gap;
    gap = 0;
    while (gap < 24 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_position  <= pos;
    in_value     <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    owed_replies.push_back(apply_list_op(op, pos, val));
  endtask

  // Hold off the sender until every owed reply has come back
  task automatic wait_replies;
    in_valid <= 1'b0;
    @(posedge clk);
    while (owed_replies.size() != 0) @(posedge clk);
  endtask

  task automatic set_idling(int mode);
    send_idle_pct  = (mode == IDLE_SEND) ? 56 : (mode == IDLE_BOTH) ? 15 : 0;
    recv_stall_pct = (mode == IDLE_RECV) ? 56 : (mode == IDLE_BOTH) ? 15 : 0;
  endtask

  // Value mix: a small pool for duplicates and hits, extremes, full range
  function automatic data_t pick_value();
    case ($urandom_range(9))
      0:       return VAL_MAX;
      1:       return VAL_MIN;
      2, 3, 4: return data_t'($urandom_range(16)) - 8;
      default: return data_t'($urandom());
    endcase
  endfunction

  // Requests on an empty list
  task automatic test_empty_list;
    send_req(OP_MINIMUM, 7'd0, 32'sd0);
    send_req(OP_LOCATE, 7'd1, VAL_MIN);
    send_req(OP_DELETE, 7'd1, 32'sd0);
    send_req(OP_RETRIEVE, 7'd1, 32'sd0);
    send_req(OP_INSERT, 7'd0, 32'sd5);
    send_req(OP_INSERT, 7'd2, 32'sd5);
    send_req(OP_RSVD_LO, POS_TOP, VAL_MAX);
  endtask

  // Short list: edges of position and value, every operation
  task automatic test_short_list;
    send_req(OP_INSERT, 7'd1, VAL_MAX);
    send_req(OP_INSERT, 7'd1, VAL_MIN);
    send_req(OP_INSERT, 7'd3, 32'sd0);
    send_req(OP_INSERT, 7'd2, -32'sd1);
    send_req(OP_INSERT, 7'd6, 32'sd9);
    send_req(OP_RETRIEVE, 7'd0, 32'sd0);
    send_req(OP_RETRIEVE, 7'd1, 32'sd0);
    send_req(OP_RETRIEVE, 7'd4, 32'sd0);
    send_req(OP_RETRIEVE, 7'd5, 32'sd0);
    send_req(OP_RETRIEVE, POS_TOP, 32'sd0);
    send_req(OP_LOCATE, 7'd0, VAL_MAX);
    send_req(OP_LOCATE, 7'd0, 32'sd77);
    send_req(OP_MINIMUM, 7'd0, 32'sd0);
    send_req(OP_DELETE, 7'd4, 32'sd0);
    send_req(OP_DELETE, POS_TOP, 32'sd0);
    send_req(OP_DELETE, 7'd0, 32'sd0);
    send_req(OP_DELETE, 7'd1, 32'sd0);
    send_req(OP_RSVD_HI, 7'd2, VAL_MIN);
    send_req(OP_MINIMUM, 7'd0, 32'sd0);
  endtask

  // Fill to capacity, poke the full list, then empty it again
  task automatic test_fill_to_capacity;
    while (list_len < CAPACITY)
      send_req(OP_INSERT, pos_t'($urandom_range(list_len + 1, 1)), pick_value());
    send_req(OP_INSERT, pos_t'($urandom_range(CAPACITY, 1)), pick_value());
    send_req(OP_INSERT, 7'd0, pick_value());
    send_req(OP_INSERT, POS_TOP, pick_value());
    send_req(OP_LOCATE, 7'd0, list_mem[CAPACITY-1]);
    send_req(OP_LOCATE, 7'd0, 32'sd1234567);
    send_req(OP_MINIMUM, 7'd0, 32'sd0);
    send_req(OP_RETRIEVE, pos_t'(CAPACITY), 32'sd0);
    send_req(OP_RETRIEVE, pos_t'(CAPACITY + 1), 32'sd0);
    send_req(OP_DELETE, pos_t'(CAPACITY + 1), 32'sd0);
    while (list_len > 0)
      send_req(OP_DELETE, pos_t'($urandom_range(list_len, 1)), 32'sd0);
  endtask

  // Random mix; ins_wt sets how hard the list is pushed toward full
  task automatic test_random_mix(int n, int ins_wt);
    op_t   op;
    pos_t  pos;
    data_t val;
    int    sel;
    int    hi;
    for (int k = 0; k < n; k++) begin
      sel = $urandom_range(99);
      if (sel < ins_wt) op = OP_INSERT;
      else begin
        sel = $urandom_range(99);
        if (sel < 35) op = OP_DELETE;
        else if (sel < 55) op = OP_LOCATE;
        else if (sel < 78) op = OP_RETRIEVE;
        else if (sel < 93) op = OP_MINIMUM;
        else op = op_t'($urandom_range(OP_RSVD_HI, OP_RSVD_LO));
      end
      // mostly legal positions for the current length
      hi = (op == OP_INSERT) ? list_len + 1 : list_len;
      if (hi >= 1 && hi <= CAPACITY && $urandom_range(99) < 88)
        pos = pos_t'($urandom_range(hi, 1));
      else
        pos = pos_t'($urandom_range(POS_TOP));
      if (op == OP_LOCATE && list_len > 0 && $urandom_range(99) < 60)
        val = list_mem[$urandom_range(list_len - 1)];
      else
        val = pick_value();
      send_req(op, pos, val);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_idling(IDLE_NONE);
    test_empty_list();
    test_short_list();
    wait_replies();

    set_idling(IDLE_BOTH);
    test_fill_to_capacity();
    wait_replies();

    for (int m = IDLE_NONE; m <= IDLE_BOTH; m++) begin
      set_idling(m);
      test_random_mix(175, 70);
      test_random_mix(175, 25);
      wait_replies();
    end

    set_idling(IDLE_NONE);
    wait_replies();
    repeat (100) @(posedge clk);
    if (owed_replies.size() != 0) begin
      $error("%0d replies never arrived", owed_replies.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("array_list_engine_test: done, clean");
    end else begin
      $display("array_list_engine_test: done, errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10ms;
    $display("array_list_engine_test: done, errors");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/alp_pkg.sv
rtl/core/alp_ram.sv
rtl/core/alp_datapath.sv
rtl/core/alp_ctrl.sv
rtl/core/array_list_engine.sv
bench/array_list_engine_test.sv
